// ----- design/hsv_to_rgb_converter_unit_assert.svh -----
// Assertion macros for the checker of the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSVRGB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSVRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/hsvrgb_pkg.sv -----
// Shared constants and types for the HSV to RGB converter.
package hsvrgb_pkg;

	localparam int unsigned HUE_FRAC_BITS_DEF = 4;

	localparam int unsigned HUE_W    = 13;
	localparam int unsigned CH_W     = 8;
	localparam int unsigned COLOUR_W = 3 * CH_W;
	localparam int unsigned SECT_W   = 3;

	// Sector quotient: hue / (60 << frac) = (hue >> (frac + 2)) / 15
	localparam int unsigned Y_W       = 11;
	localparam int unsigned QUOT_W    = 8;
	localparam int unsigned REC15_W   = 12;
	localparam logic [REC15_W-1:0] REC15 = 12'd2185;
	localparam int unsigned REC15_SH  = 15;

	// Quotient modulo six
	localparam int unsigned REC6_W    = 8;
	localparam logic [REC6_W-1:0] REC6 = 8'd171;
	localparam int unsigned REC6_SH   = 10;
	localparam logic [QUOT_W-1:0] NUM_SECT = 8'd6;

	// Term scaling: after the power-of-two shift, divide by 255 * 15
	localparam int unsigned NUM_W        = 20;
	localparam int unsigned REC_TERM_W   = 21;
	localparam logic [REC_TERM_W-1:0] REC_TERM = 21'd1122868;
	localparam int unsigned REC_TERM_SH  = 32;

	localparam logic [SECT_W-1:0] SECT_RED_YELLOW   = 3'd0;
	localparam logic [SECT_W-1:0] SECT_YELLOW_GREEN = 3'd1;
	localparam logic [SECT_W-1:0] SECT_GREEN_CYAN   = 3'd2;
	localparam logic [SECT_W-1:0] SECT_CYAN_BLUE    = 3'd3;
	localparam logic [SECT_W-1:0] SECT_BLUE_MAGENTA = 3'd4;
	localparam logic [SECT_W-1:0] SECT_MAGENTA_RED  = 3'd5;

	// Load enables for the two stages inside a term unit
	typedef struct packed {
		logic s4;
		logic s5;
	} term_en_t;

endpackage

// ----- design/hsvrgb_term.sv -----
// Two-stage scaling of one colour term: floor(brightness * coef / (255 * sector span)).
module hsvrgb_term #(
	parameter int unsigned HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
	input  logic                                                   clk,
	input  hsvrgb_pkg::term_en_t                                   en,
	input  logic [$clog2(255 * (60 << HUE_FRAC_BITS) + 1)-1:0]     coef,
	input  logic [hsvrgb_pkg::CH_W-1:0]                            val,
	output logic [hsvrgb_pkg::CH_W-1:0]                            term_s5
);

	localparam int unsigned SPAN  = 60 << HUE_FRAC_BITS;
	localparam int unsigned CW    = $clog2(255 * SPAN + 1);
	localparam int unsigned PW    = CW + hsvrgb_pkg::CH_W;
	localparam int unsigned MW    = hsvrgb_pkg::NUM_W + hsvrgb_pkg::REC_TERM_W;

	logic [PW-1:0]                  prod;
	logic [hsvrgb_pkg::NUM_W-1:0]   n_s4;
	logic [MW-1:0]                  scaled;

	// The power-of-two part of the divisor goes first; what is left stays below 2^20
	assign prod = PW'(coef) * PW'(val);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			n_s4 <= hsvrgb_pkg::NUM_W'(prod >> (HUE_FRAC_BITS + 2));
		end
	end

	// Reciprocal of 3825 is exact over the whole range of n_s4
	assign scaled = MW'(n_s4) * MW'(hsvrgb_pkg::REC_TERM);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			term_s5 <= hsvrgb_pkg::CH_W'(scaled >> hsvrgb_pkg::REC_TERM_SH);
		end
	end

endmodule

// ----- design/hsv_to_rgb_converter_unit.sv -----
// Top level of the HSV to RGB converter: six-stage pipeline, one beat per cycle while the output is not stalled.
//
// Takes one hue, saturation and brightness beat per clock cycle and returns the packed
// colour (blue 23:16, green 15:8, red 7:0) from the output stage. Throughput is
// one beat per cycle: each of the six register stages has its own valid bit and
// moves as soon as the stage after it is free, so a stall on the output fills the
// bubbles first and then holds hsv_ready low. Latency is set by the chain sector
// divide, remainder, term coefficients, brightness product, constant reciprocal
// scaling and the final sector select. Hue at or above 360 degrees wraps round the
// colour circle. No state is kept and no start-up sweep is needed.
module hsv_to_rgb_converter_unit #(
	parameter int unsigned HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              hsv_valid,
	output logic                              hsv_ready,
	input  logic [hsvrgb_pkg::HUE_W-1:0]      hue,
	input  logic [hsvrgb_pkg::CH_W-1:0]       saturation,
	input  logic [hsvrgb_pkg::CH_W-1:0]       brightness,
	output logic                              rgb_valid,
	input  logic                              rgb_ready,
	output logic [hsvrgb_pkg::COLOUR_W-1:0]   packed_colour
);

	localparam int unsigned SPAN   = 60 << HUE_FRAC_BITS;
	localparam int unsigned FULL   = 255 * SPAN;
	localparam int unsigned CW     = $clog2(FULL + 1);
	localparam int unsigned RW     = ($clog2(SPAN) < hsvrgb_pkg::HUE_W) ?
	                                 $clog2(SPAN) : hsvrgb_pkg::HUE_W;
	localparam int unsigned P15_W  = hsvrgb_pkg::Y_W + hsvrgb_pkg::REC15_W;
	localparam int unsigned P6_W   = hsvrgb_pkg::QUOT_W + hsvrgb_pkg::REC6_W;
	localparam int unsigned CH_W   = hsvrgb_pkg::CH_W;

	// Stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, rgb_valid_q;
	logic en1, en2, en3, en4, en5, en6;
	hsvrgb_pkg::term_en_t term_en;

	// Stage 1
	logic [hsvrgb_pkg::Y_W-1:0]      y;
	logic [P15_W-1:0]                p15_s1;
	logic [hsvrgb_pkg::HUE_W-1:0]    hue_s1;
	logic [CH_W-1:0]                 sat_s1, val_s1;

	// Stage 2
	logic [hsvrgb_pkg::QUOT_W-1:0]   quot;
	logic [hsvrgb_pkg::HUE_W-1:0]    quot_span;
	logic [hsvrgb_pkg::QUOT_W-1:0]   quot_s2;
	logic [P6_W-1:0]                 p6_s2;
	logic [RW-1:0]                   r_s2;
	logic [CH_W-1:0]                 sat_s2, val_s2;

	// Stage 3
	logic [hsvrgb_pkg::QUOT_W-1:0]   six_q;
	logic [CW-1:0]                   coef_p, coef_q, coef_t;
	logic [CW-1:0]                   coef_p_s3, coef_q_s3, coef_t_s3;
	logic [hsvrgb_pkg::SECT_W-1:0]   sect_s3;
	logic [CH_W-1:0]                 val_s3;

	// Stages 4 and 5
	logic [hsvrgb_pkg::SECT_W-1:0]   sect_s4, sect_s5;
	logic [CH_W-1:0]                 val_s4, val_s5;
	logic [CH_W-1:0]                 p_s5, q_s5, t_s5;

	// Output stage
	logic [CH_W-1:0]                 red, green, blue;
	logic [hsvrgb_pkg::COLOUR_W-1:0] packed_colour_q;

	// A stage loads when it is empty or its content moves on in the same cycle
	assign en6 = !rgb_valid_q || rgb_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign hsv_ready     = en1;
	assign rgb_valid     = rgb_valid_q;
	assign packed_colour = packed_colour_q;
	assign term_en       = '{s4: en4, s5: en5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			rgb_valid_q <= 1'b0;
		end else begin
			if (en1) v_s1        <= hsv_valid;
			if (en2) v_s2        <= v_s1;
			if (en3) v_s3        <= v_s2;
			if (en4) v_s4        <= v_s3;
			if (en5) v_s5        <= v_s4;
			if (en6) rgb_valid_q <= v_s5;
		end
	end

	// Stage 1: reciprocal product for the sector quotient
	assign y = hsvrgb_pkg::Y_W'(hue >> (HUE_FRAC_BITS + 2));

	always_ff @(posedge clk) begin
		if (en1) begin
			p15_s1 <= P15_W'(y) * P15_W'(hsvrgb_pkg::REC15);
			hue_s1 <= hue;
			sat_s1 <= saturation;
			val_s1 <= brightness;
		end
	end

	// Stage 2: quotient, remainder within the sector, product for the wrap modulo six
	assign quot      = hsvrgb_pkg::QUOT_W'(p15_s1 >> hsvrgb_pkg::REC15_SH);
	assign quot_span = hsvrgb_pkg::HUE_W'(32'(quot) * SPAN);

	always_ff @(posedge clk) begin
		if (en2) begin
			quot_s2 <= quot;
			p6_s2   <= P6_W'(quot) * P6_W'(hsvrgb_pkg::REC6);
			r_s2    <= RW'(hue_s1 - quot_span);
			sat_s2  <= sat_s1;
			val_s2  <= val_s1;
		end
	end

	// Stage 3: sector and the three term coefficients, all scaled by 255 * span
	assign six_q  = hsvrgb_pkg::QUOT_W'(p6_s2 >> hsvrgb_pkg::REC6_SH) * hsvrgb_pkg::NUM_SECT;
	assign coef_q = CW'(FULL) - CW'(r_s2) * CW'(sat_s2);
	assign coef_t = CW'(FULL) - (CW'(SPAN) - CW'(r_s2)) * CW'(sat_s2);
	assign coef_p = CW'(FULL) - CW'(SPAN) * CW'(sat_s2);

	always_ff @(posedge clk) begin
		if (en3) begin
			sect_s3   <= hsvrgb_pkg::SECT_W'(quot_s2 - six_q);
			coef_p_s3 <= coef_p;
			coef_q_s3 <= coef_q;
			coef_t_s3 <= coef_t;
			val_s3    <= val_s2;
		end
	end

	// Stages 4 and 5: one scaling unit per term
	hsvrgb_term #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_term_p (
		.clk     (clk),
		.en      (term_en),
		.coef    (coef_p_s3),
		.val     (val_s3),
		.term_s5 (p_s5)
	);

	hsvrgb_term #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_term_q (
		.clk     (clk),
		.en      (term_en),
		.coef    (coef_q_s3),
		.val     (val_s3),
		.term_s5 (q_s5)
	);

	hsvrgb_term #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_term_t (
		.clk     (clk),
		.en      (term_en),
		.coef    (coef_t_s3),
		.val     (val_s3),
		.term_s5 (t_s5)
	);

	always_ff @(posedge clk) begin
		if (en4) begin
			sect_s4 <= sect_s3;
			val_s4  <= val_s3;
		end
		if (en5) begin
			sect_s5 <= sect_s4;
			val_s5  <= val_s4;
		end
	end

	// Output stage: pick the terms for the sector and pack
	always_comb begin
		unique case (sect_s5)
			hsvrgb_pkg::SECT_RED_YELLOW: begin
				red = val_s5; green = t_s5; blue = p_s5;
			end
			hsvrgb_pkg::SECT_YELLOW_GREEN: begin
				red = q_s5; green = val_s5; blue = p_s5;
			end
			hsvrgb_pkg::SECT_GREEN_CYAN: begin
				red = p_s5; green = val_s5; blue = t_s5;
			end
			hsvrgb_pkg::SECT_CYAN_BLUE: begin
				red = p_s5; green = q_s5; blue = val_s5;
			end
			hsvrgb_pkg::SECT_BLUE_MAGENTA: begin
				red = t_s5; green = p_s5; blue = val_s5;
			end
			default: begin
				red = val_s5; green = p_s5; blue = q_s5;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			packed_colour_q <= {blue, green, red};
		end
	end

endmodule

// ----- design/hsvrgb_checker.sv -----
// Port-level checker for the HSV to RGB converter, bound to the top level.
`include "hsv_to_rgb_converter_unit_assert.svh"

module hsvrgb_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              hsv_valid,
	input logic                              hsv_ready,
	input logic [hsvrgb_pkg::CH_W-1:0]       saturation,
	input logic [hsvrgb_pkg::CH_W-1:0]       brightness,
	input logic                              rgb_valid,
	input logic                              rgb_ready,
	input logic [hsvrgb_pkg::COLOUR_W-1:0]   packed_colour
);

	logic [5:0] acc_hist_q;
	logic [4:0] rdy_hist_q;
	logic       flight_ok;

	// Track accepted beats and output ready in shift-register histories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_hist_q <= '0;
			rdy_hist_q <= '0;
		end else begin
			acc_hist_q <= {acc_hist_q[4:0], hsv_valid && hsv_ready};
			rdy_hist_q <= {rdy_hist_q[3:0], rgb_ready};
		end
	end

	// A beat that has reached the oldest acceptance bit, with rgb_ready high ever since, must show now
	assign flight_ok = acc_hist_q[5] && (&rdy_hist_q);

	`HSVRGB_ASSERT_NEXT(a_valid_hold, clk, arst_n, rgb_valid && !rgb_ready, rgb_valid, "rgb_valid dropped before beat was taken")
	`HSVRGB_ASSERT_NEXT(a_payload_hold, clk, arst_n, rgb_valid && !rgb_ready, $stable(packed_colour), "packed_colour changed while stalled")
	`HSVRGB_ASSERT_NOW(a_empty_ready, clk, arst_n, !rgb_valid, hsv_ready, "input stalled with empty output")
	`HSVRGB_ASSERT_NOW(a_latency, clk, arst_n, flight_ok, rgb_valid, "beat missing after six unstalled cycles")
	`HSVRGB_ASSERT_NOW(a_grey, clk, arst_n, flight_ok && ($past(saturation, 6) == 8'd0), (packed_colour[7:0] == $past(brightness, 6)) && (packed_colour[15:8] == $past(brightness, 6)) && (packed_colour[23:16] == $past(brightness, 6)), "zero saturation gave a non-grey colour")

endmodule

bind hsv_to_rgb_converter_unit hsvrgb_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.hsv_valid     (hsv_valid),
	.hsv_ready     (hsv_ready),
	.saturation    (saturation),
	.brightness    (brightness),
	.rgb_valid     (rgb_valid),
	.rgb_ready     (rgb_ready),
	.packed_colour (packed_colour)
);
